// ===== design/sspc_pkg.sv =====
package sspc_pkg;

  localparam int DATA_W    = 24;
  localparam int REG_COUNT = 8;
  localparam int REG_IDX_W = 3;
  localparam int DIV_W     = 32;
  localparam int PCT_W     = 16;

  typedef logic [DATA_W-1:0] word_t;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_EMPTY_WEIGHT   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_STABLE_DIFF    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CHANGE_ERROR   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PAPER_LIMIT    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PAMPHLET_LIMIT = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_POWER_LIMIT    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_REMOTE_LIMIT   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_COMP_LIMIT     = 3'd7;

  localparam word_t REG_RESET [REG_COUNT] = '{
    24'd14418, 24'd41, 24'd41, 24'd246, 24'd901, 24'd1106, 24'd1638, 24'd2048
  };

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_ADDED    = 3'd1,
    EV_PAPER    = 3'd2,
    EV_PAMPHLET = 3'd3,
    EV_POWER    = 3'd4,
    EV_REMOTE   = 3'd5,
    EV_COMP     = 3'd6
  } event_code_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MEAN,
    S_WRITE,
    S_WALK,
    S_WALK_END,
    S_DECIDE,
    S_CLASS,
    S_MULT,
    S_PCT_START,
    S_PCT_DIV,
    S_OUT
  } state_t;

endpackage

// ===== design/sspc_divider.sv =====
module sspc_divider
  import sspc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  word_t             divisor,
  output logic [DIV_W-1:0]  quotient,
  output logic              done
);

  localparam int CNT_W = $clog2(DIV_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DIV_W-1:0]  quo;
  word_t             rem;
  word_t             den;

  logic [DATA_W:0]   rem_sh;
  logic              fits;
  logic [DATA_W:0]   rem_sub;
  word_t             rem_next;

  // one restoring step per cycle, most significant dividend bit first
  always_comb begin
    rem_sh   = {rem, quo[DIV_W-1]};
    fits     = (rem_sh >= {1'b0, den});
    rem_sub  = rem_sh - {1'b0, den};
    rem_next = fits ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], fits};
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

// ===== design/scale_settle_and_pick_classifier_top.sv =====
// Scale settle-and-pick classifier.
//
// Input channel: sample_valid / sample_stall carry one load-cell sample per item
// (unsigned, 12 fraction bits). A zero sample is taken and dropped: no result.
// Output channel: result_valid / result_stall carry one result item per nonzero
// sample: the five-sample mean, the stable flag, the event code, the fill
// percentage and the divide fault flag.
// Configuration: cfg_write / cfg_index / cfg_data write one of eight 24-bit
// registers per cycle; write them only while the block is idle.
//
// Work per item: the walk over the mean memory (one entry per cycle through its
// single read port), then the threshold scan (one limit per cycle) when the
// mean has settled, then the serial 32-step percentage divider when an event
// is classified and its divisor is nonzero. sample_stall is high for all of
// that work; the next sample can be taken in the cycle after the result loads,
// so no new sample is taken while one is in work.
// Reset clears both rings (the mean memory through per-entry valid bits), the
// counters, the weights and result_valid; a stalled result holds in the outputs.
module scale_settle_and_pick_classifier_top
  import sspc_pkg::*;
#(
  parameter int SAMPLE_DEPTH = 5,
  parameter int MEAN_DEPTH   = 30,
  parameter int SETTLE_COUNT = 25
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  logic [DATA_W-1:0]    sample_weight,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [DATA_W-1:0]    mean_weight,
  output logic                 is_stable,
  output logic [2:0]           event_code,
  output logic signed [PCT_W-1:0] fill_pct,
  output logic                 divide_fault
);

  localparam int SUM_W  = DATA_W + $clog2(SAMPLE_DEPTH);
  localparam int SW     = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int AW     = $clog2(MEAN_DEPTH);
  localparam int WIDX_W = $clog2(MEAN_DEPTH + 1);
  localparam int CNT_W  = $clog2(SETTLE_COUNT + 2);

  // divide by SAMPLE_DEPTH: multiply by the rounded-up reciprocal, exact for
  // every sum below 2**SUM_W
  localparam int RSH     = SUM_W + $clog2(SAMPLE_DEPTH);
  localparam int RCP_W   = SUM_W + 1;
  localparam int MPROD_W = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << RSH) / SAMPLE_DEPTH + 1);

  localparam logic [SW-1:0]     SLOT_LAST = SW'(SAMPLE_DEPTH - 1);
  localparam logic [AW-1:0]     ADDR_LAST = AW'(MEAN_DEPTH - 1);
  localparam logic [WIDX_W-1:0] WALK_LAST = WIDX_W'(MEAN_DEPTH);
  localparam logic [CNT_W-1:0]  SETTLE    = CNT_W'(SETTLE_COUNT);
  localparam logic [CNT_W-1:0]  SETTLED   = CNT_W'(SETTLE_COUNT + 1);
  localparam logic [2:0]        CLASS_LAST = 3'd6;
  localparam logic signed [7:0] PCT_SCALE  = 8'sd100;
  localparam logic [DIV_W-1:0]  PCT_POS_MAX = DIV_W'(32767);
  localparam logic [DIV_W-1:0]  PCT_NEG_MAX = DIV_W'(32768);

  // configuration registers
  word_t regs [REG_COUNT];

  // sample ring with running sum
  word_t            ring [SAMPLE_DEPTH];
  logic [SW-1:0]    sslot;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_next;
  logic [MPROD_W-1:0] mean_prod;

  // mean memory
  word_t            mem [MEAN_DEPTH];
  logic [MEAN_DEPTH-1:0] mvalid;
  logic [AW-1:0]    mslot;
  logic [WIDX_W-1:0] widx;
  logic [AW-1:0]    rd_addr;
  word_t            rd_mem;
  logic             rd_vld;
  logic             rd_pending;
  logic             rd_first;
  word_t            rd_word;
  word_t            prev_mean;
  word_t            abs_diff;
  logic             agree;

  // item state
  state_t           state, state_next;
  word_t            mean;
  logic [CNT_W-1:0] count;
  word_t            settled_weight;
  word_t            full_weight;
  logic [2:0]       cidx;
  logic signed [DATA_W:0] drop;
  logic signed [DATA_W:0] thr;
  logic             below;
  event_code_t      cls_event;
  event_code_t      evt;
  logic signed [DATA_W:0] diff;
  logic signed [DATA_W:0] den;
  logic signed [DIV_W-1:0] prod;
  logic [DIV_W-1:0] prod_mag;
  logic [DATA_W:0]  den_mag;
  logic             neg;
  logic [DIV_W-1:0] neg_q;
  logic signed [PCT_W-1:0] pct;
  logic             fault;

  // percentage divider
  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  word_t            div_divisor;
  logic [DIV_W-1:0] div_quotient;
  logic             div_done;

  logic sample_take;
  logic class_end;
  logic out_load;

  sspc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  assign sample_stall = (state != S_IDLE);
  assign sample_take  = sample_valid && !sample_stall && (sample_weight != '0);

  // drop the oldest sample, add the new one
  assign sum_next = sum - SUM_W'(ring[sslot]) + SUM_W'(sample_weight);

  assign mean_prod = MPROD_W'(sum) * MPROD_W'(RECIP);

  assign rd_addr  = (widx == '0) ? ADDR_LAST : AW'(widx - 1'b1);
  assign rd_word  = rd_vld ? rd_mem : '0;
  assign abs_diff = (prev_mean > rd_word) ? (prev_mean - rd_word) : (rd_word - prev_mean);

  assign drop     = $signed({1'b0, settled_weight}) - $signed({1'b0, mean});
  assign prod_mag = prod[DIV_W-1] ? (DIV_W'(0) - prod) : prod;
  assign den_mag  = den[DATA_W] ? ((DATA_W+1)'(0) - den) : den;
  assign neg_q    = DIV_W'(0) - div_quotient;

  // one threshold per cycle, first one below wins
  always_comb begin
    case (cidx)
      3'd0:    thr = -$signed({1'b0, regs[REG_CHANGE_ERROR]});
      3'd1:    thr = $signed({1'b0, regs[REG_CHANGE_ERROR]});
      3'd2:    thr = $signed({1'b0, regs[REG_PAPER_LIMIT]});
      3'd3:    thr = $signed({1'b0, regs[REG_PAMPHLET_LIMIT]});
      3'd4:    thr = $signed({1'b0, regs[REG_POWER_LIMIT]});
      3'd5:    thr = $signed({1'b0, regs[REG_REMOTE_LIMIT]});
      3'd6:    thr = $signed({1'b0, regs[REG_COMP_LIMIT]});
      default: thr = '0;
    endcase
    below = (drop < thr);
    case (cidx)
      3'd0:    cls_event = EV_ADDED;
      3'd2:    cls_event = EV_PAPER;
      3'd3:    cls_event = EV_PAMPHLET;
      3'd4:    cls_event = EV_POWER;
      3'd5:    cls_event = EV_REMOTE;
      3'd6:    cls_event = EV_COMP;
      default: cls_event = EV_NONE;
    endcase
    if (!below) begin
      cls_event = EV_NONE;
    end
  end

  assign class_end = (state == S_CLASS) && (below || (cidx == CLASS_LAST));
  assign out_load  = (state == S_OUT) && (!result_valid || !result_stall);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state)
      S_IDLE: begin
        if (sample_take) begin
          state_next = S_MEAN;
        end
      end
      S_MEAN: state_next = S_WRITE;
      S_WRITE: state_next = S_WALK;
      S_WALK: begin
        if (widx == WALK_LAST) begin
          state_next = S_WALK_END;
        end
      end
      S_WALK_END: state_next = S_DECIDE;
      S_DECIDE: begin
        if (agree && (count == SETTLE)) begin
          state_next = S_CLASS;
        end else begin
          state_next = S_OUT;
        end
      end
      S_CLASS: begin
        if (class_end) begin
          state_next = (cls_event != EV_NONE) ? S_MULT : S_OUT;
        end
      end
      S_MULT: state_next = S_PCT_START;
      S_PCT_START: begin
        if (den == '0) begin
          state_next = S_OUT;
        end else begin
          div_start    = 1'b1;
          div_dividend = prod_mag;
          div_divisor  = den_mag[DATA_W-1:0];
          state_next   = S_PCT_DIV;
        end
      end
      S_PCT_DIV: begin
        if (div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        regs[i] <= REG_RESET[i];
      end
    end else if (cfg_write) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  // control and state that reset clears
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SAMPLE_DEPTH; i++) begin
        ring[i] <= '0;
      end
      sslot          <= '0;
      sum            <= '0;
      mslot          <= '0;
      mvalid         <= '0;
      rd_pending     <= 1'b0;
      rd_first       <= 1'b0;
      count          <= '0;
      settled_weight <= '0;
      full_weight    <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (sample_take) begin
        ring[sslot] <= sample_weight;
        sum         <= sum_next;
        sslot       <= (sslot == SLOT_LAST) ? '0 : sslot + 1'b1;
      end
      if (state == S_WRITE) begin
        mvalid[mslot] <= 1'b1;
        mslot         <= (mslot == ADDR_LAST) ? '0 : mslot + 1'b1;
      end
      rd_pending <= (state == S_WALK);
      rd_first   <= (state == S_WALK) && (widx == '0);
      if (state == S_DECIDE) begin
        if (!agree) begin
          count <= '0;
        end else if (count < SETTLE) begin
          count <= count + 1'b1;
        end else if (count != SETTLE) begin
          settled_weight <= mean;
        end
      end
      if (class_end) begin
        settled_weight <= mean;
        count          <= SETTLED;
        if (cls_event == EV_ADDED) begin
          full_weight <= mean;
        end
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // mean memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      mem[mslot] <= mean;
    end
    rd_mem <= mem[rd_addr];
    rd_vld <= mvalid[rd_addr];
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == S_MEAN) begin
      mean <= mean_prod[RSH +: DATA_W];
    end
    if (state == S_WRITE) begin
      widx  <= '0;
      agree <= 1'b1;
      evt   <= EV_NONE;
      pct   <= '0;
      fault <= 1'b0;
    end
    if (state == S_WALK) begin
      widx <= widx + 1'b1;
    end
    // first word is the last entry; each later word is checked against the one before
    if (rd_pending) begin
      prev_mean <= rd_word;
      if (!rd_first && !(abs_diff < regs[REG_STABLE_DIFF])) begin
        agree <= 1'b0;
      end
    end
    if (state == S_DECIDE) begin
      cidx <= '0;
    end
    if ((state == S_CLASS) && !class_end) begin
      cidx <= cidx + 1'b1;
    end
    if (class_end) begin
      evt  <= cls_event;
      diff <= $signed({1'b0, mean}) - $signed({1'b0, regs[REG_EMPTY_WEIGHT]});
      den  <= $signed({1'b0, (cls_event == EV_ADDED) ? mean : full_weight})
              - $signed({1'b0, regs[REG_EMPTY_WEIGHT]});
    end
    if (state == S_MULT) begin
      prod <= DIV_W'(diff) * DIV_W'(PCT_SCALE);
    end
    if (state == S_PCT_START) begin
      neg <= prod[DIV_W-1] ^ den[DATA_W];
      if (den == '0) begin
        fault <= 1'b1;
      end
    end
    // truncate toward zero, then saturate
    if ((state == S_PCT_DIV) && div_done) begin
      if (neg) begin
        pct <= (div_quotient > PCT_NEG_MAX) ? $signed(PCT_NEG_MAX[PCT_W-1:0])
                                            : $signed(neg_q[PCT_W-1:0]);
      end else begin
        pct <= (div_quotient > PCT_POS_MAX) ? $signed(PCT_POS_MAX[PCT_W-1:0])
                                            : $signed(div_quotient[PCT_W-1:0]);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      mean_weight  <= mean;
      is_stable    <= agree;
      event_code   <= evt;
      fill_pct     <= pct;
      divide_fault <= fault;
    end
  end

endmodule

// ===== design/sspc_checker.sv =====
module sspc_checker
  import sspc_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    sample_valid,
  input logic                    sample_stall,
  input logic [DATA_W-1:0]       sample_weight,
  input logic                    result_valid,
  input logic                    result_stall,
  input logic [2:0]              event_code,
  input logic signed [PCT_W-1:0] fill_pct,
  input logic                    divide_fault
);

  // a stalled result stays offered
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // a nonzero sample starts work, so the input closes on the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall && (sample_weight != '0) |=> sample_stall)
    else $error("input not closed after a nonzero sample");

  // no event means no percentage and no fault
  a_quiet_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && (event_code == EV_NONE) |-> (fill_pct == '0) && !divide_fault)
    else $error("percentage or fault without an event");

  // a fault comes only with an event and zeroes the percentage
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && divide_fault |-> (fill_pct == '0) && (event_code != EV_NONE))
    else $error("divide fault with nonzero percentage or no event");

endmodule

bind scale_settle_and_pick_classifier_top sspc_checker u_sspc_checker (
  .clk           (clk),
  .rst           (rst),
  .sample_valid  (sample_valid),
  .sample_stall  (sample_stall),
  .sample_weight (sample_weight),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .event_code    (event_code),
  .fill_pct      (fill_pct),
  .divide_fault  (divide_fault)
);

// ===== test/tb_scale_settle_and_pick_classifier_top.sv =====
module tb_scale_settle_and_pick_classifier_top;
  import sspc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLES = 5;
  localparam int MEANS   = 30;
  localparam int SETTLE  = 25;

  // Leave margin on top of the worst-case time per sample.
  localparam int DRAIN_GAP   = MEANS + 120;
  localparam int LONG_HOLD   = 600;
  localparam int CYCLE_LIMIT = 1000000;
  localparam longint TOP_WEIGHT = 16777215;

  // Hand-picked samples: field extremes, alternating bit patterns, zeros that
  // must be dropped, a run at full scale, and the empty-bin weight itself.
  localparam word_t EDGE_SAMPLES [16] = '{
    24'hFFFFFF, 24'h000000, 24'h000001, 24'h800000,
    24'h7FFFFF, 24'hAAAAAA, 24'h555555, 24'h000000,
    24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
    24'hFFFFFF, 24'h000001, 24'h003852, 24'h000000
  };

  typedef struct {
    word_t                   mean;
    logic                    stable;
    event_code_t             code;
    logic signed [PCT_W-1:0] pct;
    logic                    fault;
  } weigh_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    cfg_write = 1'b0;
  logic [REG_IDX_W-1:0]    cfg_index = '0;
  logic [DATA_W-1:0]       cfg_data  = '0;
  logic                    sample_valid  = 1'b0;
  logic                    sample_stall;
  logic [DATA_W-1:0]       sample_weight = '0;
  logic                    result_valid;
  logic                    result_stall  = 1'b0;
  logic [DATA_W-1:0]       mean_weight;
  logic                    is_stable;
  logic [2:0]              event_code;
  logic signed [PCT_W-1:0] fill_pct;
  logic                    divide_fault;

  // Samples waiting to be offered, and readings predicted but not yet seen.
  word_t         sample_queue[$];
  weigh_result_t predicted_readings[$];

  // Scale model: register copy plus both rings and the settle tracking.
  word_t shadow_regs [REG_COUNT] = REG_RESET;
  word_t sample_hist [SAMPLES]   = '{default: '0};
  word_t mean_hist   [MEANS]     = '{default: '0};
  int    sample_pos  = 0;
  int    mean_pos    = 0;
  int    settle_run  = 0;
  word_t last_weight = '0;
  word_t full_weight = '0;

  // Stimulus side state.
  word_t settle_target = 24'd20000;
  int    idle_max      = 4;
  int    hold_asked    = 0;
  int    fail_count    = 0;
  int    cycle_count   = 0;

  // Process-private scratch for the driver and the checker.
  bit            take_in;
  int            send_wait = 0;
  bit            take_out;
  int            recv_wait = 0;
  int            hold_left = 0;
  int            hold_taken = 0;
  weigh_result_t want;

  scale_settle_and_pick_classifier_top #(
    .SAMPLE_DEPTH(SAMPLES),
    .MEAN_DEPTH  (MEANS),
    .SETTLE_COUNT(SETTLE)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_weight(sample_weight),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .mean_weight  (mean_weight),
    .is_stable    (is_stable),
    .event_code   (event_code),
    .fill_pct     (fill_pct),
    .divide_fault (divide_fault)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Advance the scale model by one accepted sample and record the reading it
  // must produce. A zero sample leaves everything untouched.
  function automatic void weigh_sample(input word_t w);
    longint        total, gap, drop, ce, num, den, pct;
    word_t         avg, left;
    bit            steady;
    event_code_t   code;
    bit            fault;
    weigh_result_t r;
    if (w == '0) return;
    sample_hist[sample_pos] = w;
    sample_pos = (sample_pos + 1) % SAMPLES;
    total = 0;
    foreach (sample_hist[k]) total += longint'(sample_hist[k]);
    avg = word_t'(total / SAMPLES);
    mean_hist[mean_pos] = avg;

    // Every cyclic neighbour pair must sit strictly inside the stable bound.
    steady = 1'b1;
    for (int k = 0; k < MEANS; k++) begin
      left = mean_hist[(k + MEANS - 1) % MEANS];
      gap  = (left > mean_hist[k]) ? longint'(left - mean_hist[k])
                                   : longint'(mean_hist[k] - left);
      if (gap >= longint'(shadow_regs[REG_STABLE_DIFF])) steady = 1'b0;
    end

    code  = EV_NONE;
    fault = 1'b0;
    pct   = 0;
    if (!steady) begin
      settle_run = 0;
    end else if (settle_run >= SETTLE) begin
      if (settle_run == SETTLE) begin
        drop = longint'(last_weight) - longint'(avg);
        ce   = longint'(shadow_regs[REG_CHANGE_ERROR]);
        if (drop < -ce)                                          code = EV_ADDED;
        else if (drop < ce)                                      code = EV_NONE;
        else if (drop < longint'(shadow_regs[REG_PAPER_LIMIT]))    code = EV_PAPER;
        else if (drop < longint'(shadow_regs[REG_PAMPHLET_LIMIT])) code = EV_PAMPHLET;
        else if (drop < longint'(shadow_regs[REG_POWER_LIMIT]))    code = EV_POWER;
        else if (drop < longint'(shadow_regs[REG_REMOTE_LIMIT]))   code = EV_REMOTE;
        else if (drop < longint'(shadow_regs[REG_COMP_LIMIT]))     code = EV_COMP;
        else                                                     code = EV_NONE;
        if (code == EV_ADDED) full_weight = avg;
        if (code != EV_NONE) begin
          den = longint'(full_weight) - longint'(shadow_regs[REG_EMPTY_WEIGHT]);
          num = (longint'(avg) - longint'(shadow_regs[REG_EMPTY_WEIGHT])) * 100;
          if (den == 0) begin
            fault = 1'b1;
          end else begin
            pct = num / den;
            if (pct > 32767) pct = 32767;
            else if (pct < -32768) pct = -32768;
          end
        end
        settle_run = SETTLE + 1;
      end
      last_weight = avg;
    end else begin
      settle_run++;
    end
    mean_pos = (mean_pos + 1) % MEANS;

    r.mean   = avg;
    r.stable = steady;
    r.code   = code;
    r.pct    = pct[PCT_W-1:0];
    r.fault  = fault;
    predicted_readings.push_back(r);
  endfunction

  // Queue roughly budget nonzero samples: mostly runs held near one weight long
  // enough to settle, each stepping up or down from the last, with bursts of
  // wild samples and stray zeros in between to break stability.
  function automatic void queue_random_items(input int budget);
    int     made, len, spread, pick, band;
    longint aim, lo, hi;
    longint bounds [8];
    made = 0;
    while (made < budget) begin
      if ($urandom_range(0, 1) == 1) begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 3) == 0) begin
            sample_queue.push_back('0);
          end else begin
            sample_queue.push_back(word_t'($urandom_range(1, 24'hFFFFFF)));
            made++;
          end
        end
      end

      // Noise stays well inside the stable bound so a run can settle.
      spread = int'(shadow_regs[REG_STABLE_DIFF] / 2);
      if (spread > 4095) spread = 4095;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        aim = longint'(shadow_regs[REG_EMPTY_WEIGHT]) + longint'($urandom_range(0, 2)) - 1;
        spread = 0;
      end else if (pick <= 2) begin
        aim = longint'(settle_target) + longint'($urandom_range(0, 20000));
      end else begin
        bounds = '{0,
                   longint'(shadow_regs[REG_CHANGE_ERROR]),
                   longint'(shadow_regs[REG_PAPER_LIMIT]),
                   longint'(shadow_regs[REG_PAMPHLET_LIMIT]),
                   longint'(shadow_regs[REG_POWER_LIMIT]),
                   longint'(shadow_regs[REG_REMOTE_LIMIT]),
                   longint'(shadow_regs[REG_COMP_LIMIT]),
                   longint'(shadow_regs[REG_COMP_LIMIT]) + 600};
        band = $urandom_range(0, 6);
        lo = (bounds[band] < bounds[band+1]) ? bounds[band] : bounds[band+1];
        hi = (bounds[band] < bounds[band+1]) ? bounds[band+1] : bounds[band];
        aim = longint'(settle_target) - longint'($urandom_range(32'(lo), 32'(hi)));
      end
      if (aim > TOP_WEIGHT - spread) aim = TOP_WEIGHT - spread;
      if (aim < 1) aim = 1;
      settle_target = word_t'(aim);

      len = $urandom_range(50, 80);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 24) == 0) sample_queue.push_back('0);
        sample_queue.push_back(word_t'(aim + longint'($urandom_range(0, spread))));
      end
      made += len;
    end
  endfunction

  // Write all eight registers back to back and mirror them in the model.
  task automatic load_regs(input word_t vals [REG_COUNT]);
    for (int i = 0; i < REG_COUNT; i++) begin
      @(posedge clk);
      cfg_write <= 1'b1;
      cfg_index <= REG_IDX_W'(i);
      cfg_data  <= vals[i];
      shadow_regs[i] = vals[i];
    end
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Hold until every queued sample is taken and every reading has come back,
  // then wait a drain gap so the block is clear.
  task automatic wait_until_idle();
    do @(negedge clk);
    while (sample_queue.size() != 0 || sample_valid || predicted_readings.size() != 0);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // Sample driver: offer the next queued sample after a random gap and hold
  // it steady until the block takes it.
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      send_wait = 0;
    end else begin
      take_in = sample_valid && !sample_stall;
      if (take_in) begin
        weigh_sample(sample_weight);
        send_wait = $urandom_range(0, idle_max);
      end
      if (!sample_valid || take_in) begin
        if (send_wait > 0) begin
          send_wait--;
          sample_valid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          sample_valid  <= 1'b1;
          sample_weight <= sample_queue.pop_front();
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Reading checker: compare each accepted reading with the oldest prediction,
  // then stall for a random count; a long hold-off overrides when requested.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      take_out = result_valid && !result_stall;
      if (take_out) begin
        if (predicted_readings.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("cycle %0d: reading with none pending: mean %h stable %b code %0d",
                     cycle_count, mean_weight, is_stable, event_code);
        end else begin
          want = predicted_readings.pop_front();
          if (mean_weight !== want.mean || is_stable !== want.stable ||
              event_code !== want.code || fill_pct !== want.pct ||
              divide_fault !== want.fault) begin
            fail_count++;
            if (fail_count <= 10)
              $display("cycle %0d: expected %h/%b/%0d/%0d/%b got %h/%b/%0d/%0d/%b",
                       cycle_count, want.mean, want.stable, want.code, want.pct,
                       want.fault, mean_weight, is_stable, event_code, fill_pct,
                       divide_fault);
          end
        end
        recv_wait = $urandom_range(0, idle_max);
      end
      if (hold_taken != hold_asked) begin
        hold_taken = hold_asked;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Watchdog: give up if the run hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    word_t  plan [REG_COUNT];
    longint level;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset register values: field extremes and zeros first, then random runs.
    idle_max = 4;
    foreach (EDGE_SAMPLES[k]) sample_queue.push_back(EDGE_SAMPLES[k]);
    queue_random_items(120);
    wait_until_idle();

    // Every register at full scale: almost always stable, events unlikely.
    // Drive back to back with no idling on either side.
    plan = '{default: 24'hFFFFFF};
    load_regs(plan);
    idle_max = 0;
    queue_random_items(60);
    wait_until_idle();

    // Every register at zero: a zero bound means nothing is ever stable.
    plan = '{default: 24'h000000};
    load_regs(plan);
    idle_max = 4;
    queue_random_items(30);
    wait_until_idle();

    // Back to reset values, and hold the reading side off for a long stretch
    // while samples keep coming, so the block backs up and stalls its input.
    load_regs(REG_RESET);
    idle_max = 0;
    hold_asked++;
    queue_random_items(50);
    wait_until_idle();

    // Random settings. Pin the empty weight on the learned full weight to
    // force divide faults, then one step off it to drive the percentage into
    // saturation, then a free draw with the limits out of order.
    for (int round = 0; round < 3; round++) begin
      plan[REG_STABLE_DIFF]  = word_t'($urandom_range(20, 400));
      plan[REG_CHANGE_ERROR] = word_t'($urandom_range(0, 200));
      if (round == 0) begin
        plan[REG_EMPTY_WEIGHT] = full_weight;
      end else if (round == 1) begin
        plan[REG_EMPTY_WEIGHT] = ($urandom_range(0, 1) == 1) ? full_weight + 24'd1
                                                            : full_weight - 24'd1;
      end else begin
        plan[REG_EMPTY_WEIGHT] = word_t'($urandom_range(0, 40000));
      end
      level = longint'(plan[REG_CHANGE_ERROR]) + longint'($urandom_range(0, 300));
      for (int i = REG_PAPER_LIMIT; i <= REG_COMP_LIMIT; i++) begin
        if (round == 2) begin
          plan[i] = word_t'($urandom_range(0, 4000));
        end else begin
          level += longint'($urandom_range(1, 800));
          plan[i] = word_t'(level);
        end
      end
      load_regs(plan);
      idle_max = (round == 1) ? 0 : 4;
      queue_random_items(60);
      wait_until_idle();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
